// ===== rtl/gplm_pkg.sv =====
package gplm_pkg;

  localparam int MAX_KEYS_DEF = 128;
  localparam int TABLE_SIZE = 256;

  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_MAP   = 2'd2;

  localparam logic CFG_LOW  = 1'b0;
  localparam logic CFG_HIGH = 1'b1;

  localparam logic [6:0] LOW_RESET  = 7'd10;
  localparam logic [6:0] HIGH_RESET = 7'd100;

  // interpolation: dividend 2*num+D < 2^17, divisor 2*D < 2^9
  localparam int DIV_NW = 17;
  localparam int DIV_DW = 9;

  typedef struct packed {
    logic capture;
    logic key_write;
    logic k_clear;
    logic k_inc;
    logic lvl_save;
    logic seg_load_a;
    logic seg_load_b;
    logic seg_shift;
    logic ent_mul;
    logic div_blend;
    logic i_inc;
    logic g_write;
    logic map_setup;
    logic map_take;
    logic set_bad;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       count_bad;
    logic       lvl_ok;
    logic       k_last;
    logic       i_last;
    logic       div_busy;
    logic       map_direct;
  } dp_sts_t;

endpackage

// ===== rtl/gplm_if.sv =====
interface gplm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [6:0] key_index;
  logic [7:0] key_level;
  logic [7:0] key_red;
  logic [7:0] key_green;
  logic [7:0] key_blue;
  logic [7:0] key_count;
  logic [7:0] sample;
  modport source (output valid, op, key_index, key_level, key_red, key_green, key_blue,
                  key_count, sample, input ready);
  modport sink (input valid, op, key_index, key_level, key_red, key_green, key_blue,
                key_count, sample, output ready);
endinterface

interface gplm_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, status, red, green, blue, input ready);
  modport sink (input valid, status, red, green, blue, output ready);
endinterface

interface gplm_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gradient_palette_window_level_map.sv =====
// flow: key write and unused opcode go through dispatch to the result; map goes through
// setup and a table read, plus the 17-step serial divider when the window needs it
// build: a wait and a check state per key to check levels, then per table entry a
// multiply, one 17-step divider pass per channel, and a write; one item at a time
// reset: state machine idle, low/high percent 10/100, gradient valid bits cleared
// at once so the whole table reads black; key store is not cleared
module gradient_palette_window_level_map #(
  parameter int MAX_KEYS = gplm_pkg::MAX_KEYS_DEF
) (
  input logic         clk,
  input logic         rst,
  gplm_req_if.sink    req,
  gplm_rsp_if.source  rsp,
  gplm_cfg_if.sink    cfg
);
  import gplm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg.ready = 1'b1;

  gplm_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd(cmd), .sts(sts)
  );

  gplm_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg.valid), .cfg_idx(cfg.index), .cfg_data(cfg.data),
    .op(req.op), .key_index(req.key_index), .key_level(req.key_level),
    .key_red(req.key_red), .key_green(req.key_green), .key_blue(req.key_blue),
    .key_count(req.key_count), .sample(req.sample),
    .status(rsp.status), .red(rsp.red), .green(rsp.green), .blue(rsp.blue)
  );
endmodule

// ===== rtl/gplm_div.sv =====
module gplm_div #(
  parameter int NW = gplm_pkg::DIV_NW,
  parameter int DW = gplm_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);
  localparam int CW = $clog2(NW);

  logic [NW-1:0] acc;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem_sh;
  logic [DW-1:0] rem_next;
  logic          qbit;

  always_comb begin
    rem_sh = {rem, acc[NW-1]};
    if (rem_sh >= {1'b0, dvs}) begin
      qbit = 1'b1;
      rem_next = DW'(rem_sh - {1'b0, dvs});
    end else begin
      qbit = 1'b0;
      rem_next = rem_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      acc <= {acc[NW-2:0], qbit};
      cnt <= cnt + 1'b1;
      if (cnt == CW'(NW - 1)) busy <= 1'b0;
    end
  end

  assign quotient = acc;
endmodule

// ===== rtl/gplm_dp.sv =====
module gplm_dp #(
  parameter int MAX_KEYS = gplm_pkg::MAX_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  gplm_pkg::dp_cmd_t cmd,
  output gplm_pkg::dp_sts_t sts,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [6:0]        cfg_data,
  input  logic [1:0]        op,
  input  logic [6:0]        key_index,
  input  logic [7:0]        key_level,
  input  logic [7:0]        key_red,
  input  logic [7:0]        key_green,
  input  logic [7:0]        key_blue,
  input  logic [7:0]        key_count,
  input  logic [7:0]        sample,
  output logic              status,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue
);
  import gplm_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int KW = $clog2(MAX_KEYS + 1);
  localparam logic [8:0] MAX_KEYS_W = 9'(MAX_KEYS);

  logic [6:0] low, high;

  logic [1:0] op_r;
  logic [6:0] kidx_r;
  logic [31:0] kdata_r;
  logic [7:0] cnt_r;
  logic [7:0] sample_r;

  logic [31:0] kmem [MAX_KEYS];
  logic [31:0] krd;
  logic [KW-1:0] k;
  logic [7:0] prev_lvl;
  logic [7:0] kidx_ext;

  logic [31:0] ka, kb;
  logic [7:0] i;
  logic [7:0] span;
  logic [7:0] dn_lo, dn_hi;

  logic [DIV_NW-1:0] dvd_r [3];
  logic [DIV_NW-1:0] dvd [3];
  logic [DIV_DW-1:0] dvs [3];
  logic [DIV_NW-1:0] quo [3];
  logic [2:0] busy;
  logic [2:0] start;
  logic [7:0] chan [3];

  logic [23:0] gmem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] gvalid;
  logic [23:0] g_rd;
  logic g_vld_rd;
  logic [7:0] idx_r;

  logic bad;

  logic [8:0] offset;
  logic signed [9:0] d;
  logic signed [7:0] w;
  logic [14:0] map_dvd;
  logic [8:0] k_ext, cnt_m1;
  logic [7:0] lvl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low <= LOW_RESET;
      high <= HIGH_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_LOW) low <= cfg_data;
      else high <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= op;
      kidx_r <= key_index;
      kdata_r <= {key_level, key_red, key_green, key_blue};
      cnt_r <= key_count;
      sample_r <= sample;
    end
  end

  // key store
  assign kidx_ext = {1'b0, kidx_r};
  always_ff @(posedge clk) begin
    if (cmd.key_write && ({1'b0, kidx_ext} < MAX_KEYS_W)) kmem[kidx_ext[AW-1:0]] <= kdata_r;
    krd <= kmem[k[AW-1:0]];
  end

  assign lvl = krd[31:24];
  assign k_ext = 9'(k);
  assign cnt_m1 = {1'b0, cnt_r} - 9'd1;

  always_ff @(posedge clk) begin
    if (cmd.k_clear) k <= '0;
    else if (cmd.k_inc) k <= k + 1'b1;
    if (cmd.lvl_save) prev_lvl <= lvl;
    if (cmd.seg_load_a) ka <= krd;
    else if (cmd.seg_shift) ka <= kb;
    if (cmd.seg_load_b) begin
      kb <= krd;
      i <= ka[31:24];
    end else if (cmd.i_inc) begin
      i <= i + 8'd1;
    end
  end

  // interpolation numerators, one register stage before the dividers
  assign span = kb[31:24] - ka[31:24];
  assign dn_hi = kb[31:24] - i;
  assign dn_lo = i - ka[31:24];

  always_ff @(posedge clk) begin
    if (cmd.ent_mul) begin
      for (int c = 0; c < 3; c++) begin
        dvd_r[c] <= {(16'(ka[8*c +: 8]) * 16'(dn_hi) + 16'(kb[8*c +: 8]) * 16'(dn_lo)), 1'b0}
                    + DIV_NW'(span);
      end
    end
  end

  // window mapping
  always_comb begin
    offset = 9'((10'(low) * 10'd5) >> 1);
    w = $signed({1'b0, high}) - $signed({1'b0, low});
    d = $signed({2'b00, sample_r}) - $signed({1'b0, offset});
    map_dvd = 15'(d[7:0]) * 15'd100;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dvd[c] = dvd_r[c];
      dvs[c] = {span, 1'b0};
      start[c] = cmd.div_blend;
      chan[c] = (quo[c][DIV_NW-1:8] != '0) ? 8'hff : quo[c][7:0];
    end
    if (cmd.map_setup) begin
      dvd[0] = DIV_NW'(map_dvd);
      dvs[0] = DIV_DW'(w[6:0]);
      start[0] = !sts.map_direct;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    gplm_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
      .clk(clk), .rst(rst), .start(start[c]), .dividend(dvd[c]), .divisor(dvs[c]),
      .busy(busy[c]), .quotient(quo[c])
    );
  end

  always_ff @(posedge clk) begin
    if (cmd.map_setup) begin
      if (w <= 0) idx_r <= (d > 0) ? 8'hff : 8'h00;
      else idx_r <= 8'h00;
    end else if (cmd.map_take) begin
      idx_r <= chan[0];
    end
  end

  // gradient table, entries never written read as black
  always_ff @(posedge clk) begin
    if (cmd.g_write) gmem[i] <= {chan[2], chan[1], chan[0]};
    g_rd <= gmem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gvalid <= '0;
      g_vld_rd <= 1'b0;
    end else begin
      if (cmd.g_write) gvalid[i] <= 1'b1;
      g_vld_rd <= gvalid[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) bad <= 1'b0;
    else if (cmd.set_bad) bad <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= bad;
      if (op_r == OP_MAP && g_vld_rd) {red, green, blue} <= g_rd;
      else {red, green, blue} <= '0;
    end
  end

  always_comb begin
    sts.op = op_r;
    sts.count_bad = (cnt_r < 8'd2) || ({1'b0, cnt_r} > MAX_KEYS_W);
    sts.k_last = (k_ext == cnt_m1);
    sts.lvl_ok = ((k_ext == 9'd0) ? (lvl == 8'd0) : (lvl > prev_lvl))
                 && (!sts.k_last || lvl == 8'hff);
    sts.i_last = (i == kb[31:24]);
    sts.div_busy = |busy;
    sts.map_direct = (w <= 0) || (d < 0);
  end
endmodule

// ===== rtl/gplm_ctrl.sv =====
module gplm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gplm_pkg::dp_cmd_t cmd,
  input  gplm_pkg::dp_sts_t sts
);
  import gplm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_V_WAIT, S_V_CHECK, S_A_WAIT, S_A_LOAD, S_B_WAIT, S_B_LOAD,
    S_E_MUL, S_E_DIV, S_E_WAIT, S_E_WRITE, S_M_SETUP, S_M_WAIT, S_M_READ, S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_KEY: begin
            cmd.key_write = 1'b1;
            state_next = S_DONE;
          end
          OP_BUILD: begin
            if (sts.count_bad) begin
              cmd.set_bad = 1'b1;
              state_next = S_DONE;
            end else begin
              cmd.k_clear = 1'b1;
              state_next = S_V_WAIT;
            end
          end
          OP_MAP: state_next = S_M_SETUP;
          default: state_next = S_DONE;
        endcase
      end
      S_V_WAIT: state_next = S_V_CHECK;
      S_V_CHECK: begin
        if (!sts.lvl_ok) begin
          cmd.set_bad = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.lvl_save = 1'b1;
          if (sts.k_last) begin
            cmd.k_clear = 1'b1;
            state_next = S_A_WAIT;
          end else begin
            cmd.k_inc = 1'b1;
            state_next = S_V_WAIT;
          end
        end
      end
      S_A_WAIT: state_next = S_A_LOAD;
      S_A_LOAD: begin
        cmd.seg_load_a = 1'b1;
        cmd.k_inc = 1'b1;
        state_next = S_B_WAIT;
      end
      S_B_WAIT: state_next = S_B_LOAD;
      S_B_LOAD: begin
        cmd.seg_load_b = 1'b1;
        state_next = S_E_MUL;
      end
      S_E_MUL: begin
        cmd.ent_mul = 1'b1;
        state_next = S_E_DIV;
      end
      S_E_DIV: begin
        cmd.div_blend = 1'b1;
        state_next = S_E_WAIT;
      end
      S_E_WAIT: begin
        if (!sts.div_busy) state_next = S_E_WRITE;
      end
      S_E_WRITE: begin
        cmd.g_write = 1'b1;
        if (!sts.i_last) begin
          cmd.i_inc = 1'b1;
          state_next = S_E_MUL;
        end else if (sts.k_last) begin
          state_next = S_DONE;
        end else begin
          cmd.seg_shift = 1'b1;
          cmd.k_inc = 1'b1;
          state_next = S_B_WAIT;
        end
      end
      S_M_SETUP: begin
        cmd.map_setup = 1'b1;
        state_next = sts.map_direct ? S_M_READ : S_M_WAIT;
      end
      S_M_WAIT: begin
        if (!sts.div_busy) begin
          cmd.map_take = 1'b1;
          state_next = S_M_READ;
        end
      end
      S_M_READ: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

// ===== sim/gradient_palette_window_level_map_tb.sv =====
module gradient_palette_window_level_map_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gplm_pkg::*;

  localparam int NUM_KEYS = 128;
  localparam int PHASE_ITEMS = 220;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 40;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] key_index;
    logic [7:0] key_level;
    logic [7:0] key_red;
    logic [7:0] key_green;
    logic [7:0] key_blue;
    logic [7:0] key_count;
    logic [7:0] sample;
  } lut_req_t;

  typedef struct packed {
    logic       status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lut_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gplm_req_if req_bus();
  gplm_rsp_if rsp_bus();
  gplm_cfg_if cfg_bus();

  gradient_palette_window_level_map uut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus),
    .cfg(cfg_bus)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [31:0] key_mirror [NUM_KEYS];
  logic [23:0] palette_mirror [256];
  logic [6:0]  low_pct = LOW_RESET;
  logic [6:0]  high_pct = HIGH_RESET;

  // stimulus-side knowledge of which key slots hold data
  bit          slot_written [NUM_KEYS];

  lut_req_t    pending_items [$];
  lut_rsp_t    expected_colors [$];
  int          mismatches = 0;
  int          accepted_items = 0;
  longint      cycle_count = 0;

  initial begin
    for (int i = 0; i < 256; i++) palette_mirror[i] = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      key_mirror[i] = '0;
      slot_written[i] = 1'b0;
    end
  end

  function automatic logic [7:0] blend_chan(int ca, int cb, int la, int lb, int i);
    int den;
    int num;
    int v;
    den = lb - la;
    num = ca * (lb - i) + cb * (i - la);
    v = (2 * num + den) / (2 * den);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic build_palette(int count);
    int la;
    int lb;
    logic [31:0] ka;
    logic [31:0] kb;
    if (count < 2 || count > NUM_KEYS) return 1'b1;
    if (key_mirror[0][31:24] != 8'd0 || key_mirror[count-1][31:24] != 8'd255) return 1'b1;
    for (int k = 0; k + 1 < count; k++)
      if (key_mirror[k+1][31:24] <= key_mirror[k][31:24]) return 1'b1;
    for (int k = 0; k + 1 < count; k++) begin
      ka = key_mirror[k];
      kb = key_mirror[k+1];
      la = ka[31:24];
      lb = kb[31:24];
      for (int i = la; i <= lb; i++)
        palette_mirror[i] = {blend_chan(ka[23:16], kb[23:16], la, lb, i),
                             blend_chan(ka[15:8], kb[15:8], la, lb, i),
                             blend_chan(ka[7:0], kb[7:0], la, lb, i)};
    end
    return 1'b0;
  endfunction

  function automatic int window_index(int s);
    int offset;
    int w;
    int d;
    int q;
    offset = (int'(low_pct) * 5) / 2;
    w = int'(high_pct) - int'(low_pct);
    d = s - offset;
    if (w <= 0) return (d > 0) ? 255 : 0;
    if (d < 0) return 0;
    q = (d * 100) / w;
    return (q > 255) ? 255 : q;
  endfunction

  function automatic lut_rsp_t predict_color(lut_req_t it);
    lut_rsp_t r;
    r = '0;
    case (it.op)
      OP_KEY: key_mirror[it.key_index] =
          {it.key_level, it.key_red, it.key_green, it.key_blue};
      OP_BUILD: r.status = build_palette(it.key_count);
      OP_MAP: {r.red, r.green, r.blue} = palette_mirror[window_index(it.sample)];
      default: ;
    endcase
    return r;
  endfunction

  function automatic lut_req_t random_item(logic [1:0] op);
    lut_req_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(lut_req_t)-1:0];
    it.op = op;
    return it;
  endfunction

  task automatic push_key(int idx, int lvl, int r, int g, int b);
    lut_req_t it;
    it = random_item(OP_KEY);
    it.key_index = 7'(idx);
    it.key_level = 8'(lvl);
    it.key_red = 8'(r);
    it.key_green = 8'(g);
    it.key_blue = 8'(b);
    slot_written[idx] = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic push_build(int count);
    lut_req_t it;
    it = random_item(OP_BUILD);
    it.key_count = 8'(count);
    pending_items.push_back(it);
  endtask

  task automatic push_map(int s);
    lut_req_t it;
    it = random_item(OP_MAP);
    it.sample = 8'(s);
    pending_items.push_back(it);
  endtask

  function automatic bit slots_ready(int count);
    for (int k = 0; k < count; k++)
      if (!slot_written[k]) return 1'b0;
    return 1'b1;
  endfunction

  // strictly rising key set from level 0 to 255, sometimes broken on purpose
  task automatic push_key_set(int n, bit corrupt, output int used);
    int prev;
    int hi;
    int lvl;
    int bad_slot;
    prev = 0;
    bad_slot = $urandom_range(0, n - 1);
    for (int k = 0; k < n; k++) begin
      if (k == 0) lvl = 0;
      else if (k == n - 1) lvl = 255;
      else begin
        hi = 255 - (n - 1 - k);
        lvl = prev + 1 + $urandom_range(0, 2 * (hi - prev - 1) / (n - k));
        if (lvl > hi) lvl = hi;
      end
      prev = lvl;
      if (corrupt && k == bad_slot) lvl = $urandom_range(0, 255);
      push_key(k, lvl, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    end
    used = n;
  endtask

  task automatic write_reg(logic idx, logic [6:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == CFG_LOW) low_pct = value;
    else high_pct = value;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || req_bus.valid || expected_colors.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase();
    int made;
    int builds;
    int n;
    int used;
    int sel;
    lut_req_t it;
    made = 0;
    builds = 0;
    while (made < PHASE_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 5 && builds < 3) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, NUM_KEYS) : $urandom_range(2, 10);
        push_key_set(n, $urandom_range(0, 3) == 0, used);
        push_build(($urandom_range(0, 4) == 0) ? $urandom_range(2, n) : n);
        builds++;
        made += used + 1;
      end else if (sel < 9) begin
        case ($urandom_range(0, 2))
          0: push_build($urandom_range(0, 1));
          1: push_build($urandom_range(NUM_KEYS + 1, 255));
          default: begin
            n = $urandom_range(2, 16);
            if (builds < 3 && slots_ready(n)) begin
              push_build(n);
              builds++;
            end else push_build(0);
          end
        endcase
        made++;
      end else if (sel < 13) begin
        if ($urandom_range(0, 1)) pending_items.push_back(random_item(OP_UNUSED));
        else begin
          it = random_item(OP_KEY);
          push_key(it.key_index, it.key_level, it.key_red, it.key_green, it.key_blue);
        end
        made++;
      end else begin
        push_map($urandom_range(0, 255));
        made++;
      end
    end
  endtask

  // input side: bursts with random gaps
  int burst_left = 8;
  int gap_left = 0;
  lut_req_t current_item;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      req_bus.valid <= 1'b0;
      {req_bus.op, req_bus.key_index, req_bus.key_level, req_bus.key_red,
       req_bus.key_green, req_bus.key_blue, req_bus.key_count, req_bus.sample} <= '0;
    end else if (!req_bus.valid || req_bus.ready) begin
      if (req_bus.valid) begin
        expected_colors.push_back(predict_color(current_item));
        accepted_items <= accepted_items + 1;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_bus.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        current_item = pending_items.pop_front();
        req_bus.valid <= 1'b1;
        {req_bus.op, req_bus.key_index, req_bus.key_level, req_bus.key_red,
         req_bus.key_green, req_bus.key_blue, req_bus.key_count,
         req_bus.sample} <= current_item;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // output side stall pattern, plus one long hold-off once traffic is flowing
  int hold_left = 0;
  bit hold_done = 1'b0;
  int ready_mode = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else if (!hold_done && accepted_items > 300) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      rsp_bus.ready <= 1'b0;
    end else begin
      if (cycle_count % 64 == 0) ready_mode <= $urandom_range(0, 2);
      case (ready_mode)
        0: rsp_bus.ready <= 1'b1;
        1: rsp_bus.ready <= 1'($urandom_range(0, 1));
        default: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    lut_rsp_t want;
    lut_rsp_t got;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got = {rsp_bus.status, rsp_bus.red, rsp_bus.green, rsp_bus.blue};
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = expected_colors.pop_front();
        if (got.status !== want.status || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d rgb %h %h %h, got status %0d rgb %h %h %h",
                     want.status, want.red, want.green, want.blue,
                     got.status, got.red, got.green, got.blue);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL gradient_palette_window_level_map");
      $finish;
    end
  end

  initial begin
    logic [6:0] lows [8];
    logic [6:0] highs [8];
    lows  = '{7'd0, 7'd0, 7'd100, 7'd127, 7'd0, 7'd127, 7'd40, 7'd0};
    highs = '{7'd100, 7'd0, 7'd0, 7'd127, 7'd127, 7'd0, 7'd45, 7'd1};
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_LOW;
    cfg_bus.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: black table, extreme keys, rejected builds, unused opcode
    push_map(0);
    push_map(255);
    push_key(0, 0, 0, 0, 0);
    push_key(1, 255, 255, 255, 255);
    push_build(2);
    push_map(0);
    push_map(128);
    push_map(255);
    push_key(127, 128, 170, 85, 1);
    push_build(0);
    push_build(1);
    push_build(200);
    push_build(255);
    push_key(0, 5, 255, 0, 0);
    push_build(2);
    push_key(1, 254, 0, 255, 0);
    push_key(0, 0, 255, 0, 255);
    push_build(2);
    push_key(1, 255, 0, 0, 255);
    push_build(2);
    pending_items.push_back(random_item(OP_UNUSED));
    push_map(24);
    push_map(25);
    push_map(26);
    drain();

    random_phase();
    drain();
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_LOW, (p == 7) ? 7'($urandom_range(0, 127)) : lows[p]);
      write_reg(CFG_HIGH, (p == 7) ? 7'($urandom_range(0, 127)) : highs[p]);
      random_phase();
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS gradient_palette_window_level_map");
    end else begin
      $display("FAIL gradient_palette_window_level_map");
    end
    $finish;
  end

endmodule

// ===== gradient_palette_window_level_map.f =====
rtl/gplm_pkg.sv
rtl/gplm_if.sv
rtl/gplm_div.sv
rtl/gplm_dp.sv
rtl/gplm_ctrl.sv
rtl/gradient_palette_window_level_map.sv
sim/gradient_palette_window_level_map_tb.sv
